// ----- hdl/hcps_pkg.sv -----
package hcps_pkg;

  localparam int unsigned COUNTS_PER_EDGE = 117;

  localparam logic [19:0] SPEED_MAX = 20'hFFFFF;
  localparam logic [27:0] SPEED_NUM = 28'd256000000;
  localparam int unsigned DIV_STEPS = 28;
  localparam int unsigned DIV_BITS  = $clog2(DIV_STEPS);

  localparam logic signed [49:0] C_BIAS = 50'sd838861;
  localparam logic signed [47:0] C_POS  = 48'sd9437;
  localparam logic [8:0]         DUTY_FULL = 9'd256;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    CFG_ORIGIN     = 3'd0,
    CFG_LEAD       = 3'd1,
    CFG_TARGET_CNT = 3'd2,
    CFG_TARGET_VEL = 3'd3,
    CFG_VEL_GAIN   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_DUTY,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    logic [2:0]  origin_state;
    logic        lead_forward;
    logic [31:0] target_count;
    logic [15:0] target_velocity;
    logic [15:0] velocity_gain;
  } cfg_t;

  // one classified word handed from the front to the back
  typedef struct packed {
    logic        op;
    logic [19:0] interval_us;
    logic [5:0]  pattern;
  } item_t;

  function automatic logic [2:0] rotor_state(input logic [2:0] hall);
    logic [2:0] st;
    case (hall)
      3'd0:    st = 3'd7;
      3'd1:    st = 3'd5;
      3'd2:    st = 3'd3;
      3'd3:    st = 3'd4;
      3'd4:    st = 3'd1;
      3'd5:    st = 3'd0;
      3'd6:    st = 3'd2;
      default: st = 3'd7;
    endcase
    return st;
  endfunction

  function automatic logic [5:0] drive_lookup(input logic [2:0] idx);
    logic [5:0] p;
    case (idx)
      3'd0:    p = 6'h12;
      3'd1:    p = 6'h18;
      3'd2:    p = 6'h09;
      3'd3:    p = 6'h21;
      3'd4:    p = 6'h24;
      3'd5:    p = 6'h06;
      default: p = 6'h00;
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/hcps_front.sv -----
module hcps_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [2:0]        hall_i,
  input  logic [19:0]       interval_us_i,
  input  hcps_pkg::cfg_t    cfg_i,
  output logic              push_o,
  output hcps_pkg::item_t   item_o,
  input  logic              q_ready_i
);

  logic [2:0]        st;
  logic signed [5:0] v;
  logic [2:0]        idx;

  always_comb begin
    st = hcps_pkg::rotor_state(hall_i);
    // state - origin + lead + 6, lead is +2 or -2
    v = $signed({3'b000, st}) - $signed({3'b000, cfg_i.origin_state})
        + (cfg_i.lead_forward ? 6'sd8 : 6'sd4);
    // truncating remainder: negative values stay negative and wrap to 5..7
    if (v < 0) begin
      idx = 3'(v + 6'sd8);
    end else if (v >= 6'sd12) begin
      idx = 3'(v - 6'sd12);
    end else if (v >= 6'sd6) begin
      idx = 3'(v - 6'sd6);
    end else begin
      idx = v[2:0];
    end
    item_o.op          = op_i;
    item_o.interval_us = interval_us_i;
    item_o.pattern     = hcps_pkg::drive_lookup(idx);
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

endmodule

// ----- hdl/hcps_queue.sv -----
module hcps_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hcps_pkg::item_t item_i,
  output logic            ready_o,
  input  logic            pop_i,
  output hcps_pkg::item_t item_o,
  output logic            valid_o
);

  hcps_pkg::item_t mem_q [hcps_pkg::QUEUE_DEPTH];
  logic [hcps_pkg::QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [hcps_pkg::QPTR_BITS:0]   cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign ready_o = (cnt_q != (hcps_pkg::QPTR_BITS+1)'(hcps_pkg::QUEUE_DEPTH));
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == hcps_pkg::QPTR_BITS'(hcps_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == hcps_pkg::QPTR_BITS'(hcps_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- hdl/hcps_back.sv -----
module hcps_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hcps_pkg::cfg_t  cfg_i,
  input  logic            head_valid_i,
  input  hcps_pkg::item_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [5:0]      drive_pattern_o,
  output logic [8:0]      duty_o,
  output logic [31:0]     position_count_o,
  output logic [19:0]     speed_o
);

  hcps_pkg::back_state_e state_q, state_d;

  logic [31:0] pos_q, pos_d;
  logic [19:0] speed_q, speed_d;
  logic [8:0]  duty_q, duty_d;

  logic [19:0] divisor_q;
  logic [19:0] rem_q;
  logic [27:0] quo_q;
  logic [hcps_pkg::DIV_BITS-1:0] bit_q;
  logic [5:0]  pat_q;

  logic signed [47:0] prod_pos_q;
  logic signed [36:0] prod_vel_q;
  logic signed [49:0] vneed_q;

  logic out_valid_q;
  logic [5:0]  out_pat_q;
  logic [8:0]  out_duty_q;
  logic [31:0] out_pos_q;
  logic [19:0] out_speed_q;

  logic out_free, take_op0, take_op1, load_done;
  logic [20:0] trial;
  logic        ge;
  logic [20:0] rem_next;
  logic [27:0] quo_next;
  logic [32:0] pos_sum;
  logic signed [32:0] err;
  logic signed [49:0] vneed, vlim, diff;
  logic [36:0] dq;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hcps_pkg::ST_IDLE: begin
        if (head_valid_i && head_i.op) state_d = hcps_pkg::ST_DIV;
      end
      hcps_pkg::ST_DIV: begin
        if (bit_q == '0) state_d = hcps_pkg::ST_MUL;
      end
      hcps_pkg::ST_MUL:  state_d = hcps_pkg::ST_SUM;
      hcps_pkg::ST_SUM:  state_d = hcps_pkg::ST_DUTY;
      hcps_pkg::ST_DUTY: state_d = hcps_pkg::ST_DONE;
      hcps_pkg::ST_DONE: begin
        if (out_free) state_d = hcps_pkg::ST_IDLE;
      end
      default: state_d = hcps_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    take_op0  = 1'b0;
    take_op1  = 1'b0;
    load_done = 1'b0;
    case (state_q)
      hcps_pkg::ST_IDLE: begin
        take_op0 = head_valid_i && !head_i.op && out_free;
        take_op1 = head_valid_i && head_i.op;
      end
      hcps_pkg::ST_DONE: load_done = out_free;
      default: ;
    endcase
  end

  assign pop_o = take_op0 || take_op1;

  // datapath
  always_comb begin
    trial    = {rem_q, hcps_pkg::SPEED_NUM[bit_q]};
    ge       = (trial >= {1'b0, divisor_q});
    rem_next = ge ? trial - {1'b0, divisor_q} : trial;
    quo_next = {quo_q[26:0], ge};

    pos_sum = {1'b0, pos_q} + 33'(hcps_pkg::COUNTS_PER_EDGE);
    pos_d   = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];

    speed_d = (quo_next > 28'(hcps_pkg::SPEED_MAX)) ? hcps_pkg::SPEED_MAX : quo_next[19:0];

    err = $signed({1'b0, cfg_i.target_count}) - $signed({1'b0, pos_q});

    vneed = hcps_pkg::C_BIAS + 50'(prod_pos_q) - 50'(prod_vel_q);
    vlim  = $signed({22'd0, cfg_i.target_velocity, 12'd0});
    if (vneed > vlim) vneed = vlim;

    diff = vneed_q - $signed({18'd0, speed_q, 12'd0});
    dq   = 37'(diff >>> 13);
    if (diff <= 0 || pos_q >= cfg_i.target_count) begin
      duty_d = '0;
    end else if (dq > 37'(hcps_pkg::DUTY_FULL)) begin
      duty_d = hcps_pkg::DUTY_FULL;
    end else begin
      duty_d = dq[8:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hcps_pkg::ST_IDLE;
      pos_q       <= '0;
      speed_q     <= '0;
      duty_q      <= hcps_pkg::DUTY_FULL;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take_op1) pos_q <= pos_d;
      if (state_q == hcps_pkg::ST_DIV && bit_q == '0) speed_q <= speed_d;
      if (state_q == hcps_pkg::ST_DUTY) duty_q <= duty_d;
      if (take_op0 || load_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_op1) begin
      divisor_q <= head_i.interval_us;
      pat_q     <= head_i.pattern;
      rem_q     <= '0;
      quo_q     <= '0;
      bit_q     <= hcps_pkg::DIV_BITS'(hcps_pkg::DIV_STEPS - 1);
    end else if (state_q == hcps_pkg::ST_DIV) begin
      // one quotient bit a cycle, numerator MSB first
      rem_q <= rem_next[19:0];
      quo_q <= quo_next;
      bit_q <= bit_q - 1'b1;
    end
    if (state_q == hcps_pkg::ST_MUL) begin
      prod_pos_q <= 48'(err) * hcps_pkg::C_POS;
      prod_vel_q <= 37'($signed(cfg_i.velocity_gain)) * 37'($signed({1'b0, speed_q}));
    end
    if (state_q == hcps_pkg::ST_SUM) vneed_q <= vneed;
    if (take_op0) begin
      out_pat_q   <= head_i.pattern;
      out_duty_q  <= duty_q;
      out_pos_q   <= pos_q;
      out_speed_q <= speed_q;
    end else if (load_done) begin
      out_pat_q   <= pat_q;
      out_duty_q  <= duty_q;
      out_pos_q   <= pos_q;
      out_speed_q <= speed_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_pattern_o  = out_pat_q;
  assign duty_o           = out_duty_q;
  assign position_count_o = out_pos_q;
  assign speed_o          = out_speed_q;

endmodule

// ----- hdl/hall_commutation_position_speed_ctrl_unit.sv -----
// Commutation-only word (op 0): the result passes through the queue and the output register,
// one word per cycle while the back end is idle and the output is not stalled. Speed-sample
// word (op 1): the back end runs the bit-serial speed divider, then the MUL, SUM and DUTY states.
// A 2-word queue lets the input side keep accepting until it is full while the back end is busy.
// Reset (async, active low): registers to their documented defaults, position 0,
// speed 0, duty full, queue and output register empty.
module hall_commutation_position_speed_ctrl_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [2:0]  hall_i,
  input  logic [19:0] interval_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  drive_pattern_o,
  output logic [8:0]  duty_o,
  output logic [31:0] position_count_o,
  output logic [19:0] speed_o
);

  hcps_pkg::cfg_t  cfg_q;
  hcps_pkg::item_t front_item, head_item;
  logic push, q_ready, pop, head_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_state    <= 3'd0;
      cfg_q.lead_forward    <= 1'b0;
      cfg_q.target_count    <= 32'hFFFF_FFFF;
      cfg_q.target_velocity <= 16'd1280;
      cfg_q.velocity_gain   <= 16'd573;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hcps_pkg::CFG_ORIGIN:     cfg_q.origin_state    <= cfg_data_i[2:0];
        hcps_pkg::CFG_LEAD:       cfg_q.lead_forward    <= cfg_data_i[0];
        hcps_pkg::CFG_TARGET_CNT: cfg_q.target_count    <= cfg_data_i;
        hcps_pkg::CFG_TARGET_VEL: cfg_q.target_velocity <= cfg_data_i[15:0];
        hcps_pkg::CFG_VEL_GAIN:   cfg_q.velocity_gain   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  hcps_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .hall_i        (hall_i),
    .interval_us_i (interval_us_i),
    .cfg_i         (cfg_q),
    .push_o        (push),
    .item_o        (front_item),
    .q_ready_i     (q_ready)
  );

  hcps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .item_o  (head_item),
    .valid_o (head_valid)
  );

  hcps_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .head_valid_i     (head_valid),
    .head_i           (head_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_pattern_o  (drive_pattern_o),
    .duty_o           (duty_o),
    .position_count_o (position_count_o),
    .speed_o          (speed_o)
  );

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_o <= hcps_pkg::DUTY_FULL)
    else $error("duty above full scale");

  a_two_switches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(drive_pattern_o) == 2 || drive_pattern_o == 6'd0))
    else $error("drive pattern enables other than two switches");

  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_ready |-> !push)
    else $error("word pushed into full queue");

endmodule
